// ===== rtl/lrf_pkg.sv =====
`timescale 1ns / 1ps
package lrf_pkg;

   localparam int HEADER_BYTES     = 7;
   localparam int MIN_BLOCK_BYTES  = HEADER_BYTES + 2;
   localparam int BLOCK_SIZE_RESET = 32768;
   localparam int CSR_W            = 16;
   localparam int OFFSET_W         = 15;
   localparam int COUNT_W          = 32;
   localparam int LENGTH_W         = 16;

   localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
   localparam logic [31:0] MASK_DELTA = 32'hA282_EAD8;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      FRAG_FULL   = 3'd1,
      FRAG_FIRST  = 3'd2,
      FRAG_MIDDLE = 3'd3,
      FRAG_LAST   = 3'd4
   } frag_kind_type;

   typedef struct packed {
      logic                  done_valid;
      logic [OFFSET_W-1:0]   done_offset;
      logic                  data_valid;
      logic [OFFSET_W-1:0]   data_offset;
      logic [7:0]            data_byte;
      logic                  hdr_valid;
      logic [OFFSET_W-1:0]   hdr_start;
      frag_kind_type         hdr_kind;
      logic [LENGTH_W-1:0]   hdr_length;
      logic [31:0]           hdr_crc;
      logic [COUNT_W-1:0]    count;
      logic                  flushed;
   } cmd_type;

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return ~c;
   endfunction

   function automatic logic [31:0] crc_mask(input logic [31:0] c);
      return {c[14:0], c[31:15]} + MASK_DELTA;
   endfunction

   localparam logic [31:0] CRC_SEED_FULL   = crc32c_byte(32'h0, 8'(FRAG_FULL));
   localparam logic [31:0] CRC_SEED_FIRST  = crc32c_byte(32'h0, 8'(FRAG_FIRST));
   localparam logic [31:0] CRC_SEED_MIDDLE = crc32c_byte(32'h0, 8'(FRAG_MIDDLE));
   localparam logic [31:0] CRC_SEED_LAST   = crc32c_byte(32'h0, 8'(FRAG_LAST));

endpackage

// ===== rtl/lrf_req_if.sv =====
`timescale 1ns / 1ps
interface lrf_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   logic       payload_last;

   modport source (output valid, output opcode, output data_byte, output payload_last,
                   input ready);
   modport sink (input valid, input opcode, input data_byte, input payload_last,
                 output ready);
endinterface

// ===== rtl/lrf_rsp_if.sv =====
`timescale 1ns / 1ps
interface lrf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    kind;
   logic [lrf_pkg::OFFSET_W-1:0]  offset;
   logic [7:0]                    out_byte;
   logic [lrf_pkg::COUNT_W-1:0]   block_count;
   logic                          flushed_during_payload;
   logic                          run_end;

   modport source (output valid, output kind, output offset, output out_byte,
                   output block_count, output flushed_during_payload, output run_end,
                   input ready);
   modport sink (input valid, input kind, input offset, input out_byte,
                 input block_count, input flushed_during_payload, input run_end,
                 output ready);
endinterface

// ===== rtl/lrf_csr_if.sv =====
`timescale 1ns / 1ps
interface lrf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lrf_pkg::CSR_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/log_record_fragmenter_crc32c_top.sv =====
`timescale 1ns / 1ps
// A request's first result passes the command queue, then the back end's output register.
// The front end takes one request per cycle while the queue has room; the back end drives
// one result per cycle while rsp_ch is ready, so a request that closes a fragment yields 8
// results, 9 if it also closes a block; the command queue absorbs these header bursts.
// Reset: synchronous, active high; clears control state, block size returns to 32768.
module log_record_fragmenter_crc32c_top #(
   parameter int MAX_BLOCK_BYTES = 32768,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic       clock,
   input  logic       reset,
   lrf_req_if.sink    req_ch,
   lrf_csr_if.sink    csr_ch,
   lrf_rsp_if.source  rsp_ch
);

   lrf_pkg::cmd_type front_cmd;
   lrf_pkg::cmd_type head_cmd;
   logic             front_valid;
   logic             queue_ready;
   logic             head_valid;
   logic             head_pop;

   lrf_front #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .cmd_ready (queue_ready),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   lrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_cmd),
      .in_ready  (queue_ready),
      .out_valid (head_valid),
      .out_data  (head_cmd),
      .pop       (head_pop)
   );

   lrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .pop       (head_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== rtl/lrf_front.sv =====
`timescale 1ns / 1ps
module lrf_front #(
   parameter int MAX_BLOCK_BYTES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   lrf_req_if.sink           req_ch,
   lrf_csr_if.sink           csr_ch,
   input  logic              cmd_ready,
   output logic              cmd_valid,
   output lrf_pkg::cmd_type  cmd
);

   localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
   localparam logic [POS_W-1:0] HDR_P = POS_W'(lrf_pkg::HEADER_BYTES);
   localparam logic [POS_W:0] HDR_EXT = (POS_W + 1)'(lrf_pkg::HEADER_BYTES);
   localparam logic [POS_W-1:0] RESET_SIZE =
      POS_W'((MAX_BLOCK_BYTES < lrf_pkg::BLOCK_SIZE_RESET) ?
             MAX_BLOCK_BYTES : lrf_pkg::BLOCK_SIZE_RESET);
   localparam logic [16:0] MIN_W = 17'(lrf_pkg::MIN_BLOCK_BYTES);
   localparam logic [16:0] MAX_W = 17'(MAX_BLOCK_BYTES);

   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] active_ff, active_in;
   logic [POS_W-1:0] size_cfg_ff, size_cfg_in;
   logic [31:0]      blocks_ff, blocks_in;
   logic [31:0]      crc_a_ff, crc_a_in;
   logic [31:0]      crc_b_ff, crc_b_in;
   logic             frag_open_ff, frag_open_in;
   logic             payload_open_ff, payload_open_in;
   logic             is_first_ff, is_first_in;
   logic             flushed_ff, flushed_in;

   logic             accept;
   logic [16:0]      csr_wide;
   logic [POS_W-1:0] fill_eff, start_v, len_v, pos_v, len_n, pos_n;
   logic [31:0]      crc_a_v, crc_b_v;

   assign req_ch.ready = cmd_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && cmd_ready;
   assign cmd_valid    = accept && (cmd.done_valid || cmd.data_valid);

   always_comb begin
      csr_wide = 17'(csr_ch.data);
      if (csr_wide < MIN_W) begin
         size_cfg_in = POS_W'(lrf_pkg::MIN_BLOCK_BYTES);
      end else if (csr_wide > MAX_W) begin
         size_cfg_in = POS_W'(MAX_BLOCK_BYTES);
      end else begin
         size_cfg_in = POS_W'(csr_wide);
      end
   end

   always_comb begin
      fill_in         = fill_ff;
      start_in        = start_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      active_in       = active_ff;
      blocks_in       = blocks_ff;
      crc_a_in        = crc_a_ff;
      crc_b_in        = crc_b_ff;
      frag_open_in    = frag_open_ff;
      payload_open_in = payload_open_ff;
      is_first_in     = is_first_ff;
      flushed_in      = flushed_ff;
      fill_eff        = fill_ff;
      start_v         = start_ff;
      len_v           = len_ff;
      pos_v           = pos_ff;
      crc_a_v         = crc_a_ff;
      crc_b_v         = crc_b_ff;
      len_n           = len_ff;
      pos_n           = pos_ff;
      cmd             = '0;
      cmd.hdr_kind    = lrf_pkg::FRAG_FULL;

      if (req_ch.opcode == lrf_pkg::OP_FLUSH) begin
         if (!payload_open_ff && fill_ff != '0) begin
            cmd.done_valid  = 1'b1;
            cmd.done_offset = lrf_pkg::OFFSET_W'(fill_ff);
            blocks_in       = blocks_ff + 32'd1;
            fill_in         = '0;
         end
         cmd.count   = blocks_in;
         cmd.flushed = flushed_ff;
      end else begin
         if (!frag_open_ff) begin
            payload_open_in = 1'b1;
            if (!payload_open_ff) begin
               flushed_in = 1'b0;
            end
            if (({1'b0, fill_ff} + HDR_EXT) >= {1'b0, active_ff}) begin
               flushed_in      = 1'b1;
               blocks_in       = blocks_ff + 32'd1;
               cmd.done_valid  = 1'b1;
               cmd.done_offset = lrf_pkg::OFFSET_W'(fill_ff);
               fill_eff        = '0;
            end
            if (fill_eff == '0) begin
               active_in = size_cfg_ff;
            end
            start_v = fill_eff;
            len_v   = '0;
            pos_v   = fill_eff + HDR_P;
            crc_a_v = is_first_ff ? lrf_pkg::CRC_SEED_FULL : lrf_pkg::CRC_SEED_LAST;
            crc_b_v = is_first_ff ? lrf_pkg::CRC_SEED_FIRST : lrf_pkg::CRC_SEED_MIDDLE;
         end

         len_n    = len_v + POS_W'(1);
         pos_n    = pos_v + POS_W'(1);
         crc_a_in = lrf_pkg::crc32c_byte(crc_a_v, req_ch.data_byte);
         crc_b_in = lrf_pkg::crc32c_byte(crc_b_v, req_ch.data_byte);

         cmd.data_valid  = 1'b1;
         cmd.data_offset = lrf_pkg::OFFSET_W'(pos_v);
         cmd.data_byte   = req_ch.data_byte;
         cmd.hdr_start   = lrf_pkg::OFFSET_W'(start_v);
         cmd.hdr_length  = lrf_pkg::LENGTH_W'(len_n);

         start_in     = start_v;
         len_in       = len_n;
         pos_in       = pos_n;
         fill_in      = fill_eff;
         frag_open_in = 1'b1;

         if (req_ch.payload_last) begin
            cmd.hdr_valid   = 1'b1;
            cmd.hdr_kind    = is_first_ff ? lrf_pkg::FRAG_FULL : lrf_pkg::FRAG_LAST;
            cmd.hdr_crc     = crc_a_in;
            fill_in         = pos_n;
            frag_open_in    = 1'b0;
            is_first_in     = 1'b1;
            payload_open_in = 1'b0;
         end else if (pos_n >= active_in) begin
            cmd.hdr_valid = 1'b1;
            cmd.hdr_kind  = is_first_ff ? lrf_pkg::FRAG_FIRST : lrf_pkg::FRAG_MIDDLE;
            cmd.hdr_crc   = crc_b_in;
            fill_in       = pos_n;
            frag_open_in  = 1'b0;
            is_first_in   = 1'b0;
         end

         cmd.count   = blocks_in;
         cmd.flushed = flushed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff         <= '0;
         start_ff        <= '0;
         len_ff          <= '0;
         pos_ff          <= '0;
         active_ff       <= RESET_SIZE;
         size_cfg_ff     <= RESET_SIZE;
         blocks_ff       <= '0;
         crc_a_ff        <= '0;
         crc_b_ff        <= '0;
         frag_open_ff    <= 1'b0;
         payload_open_ff <= 1'b0;
         is_first_ff     <= 1'b1;
         flushed_ff      <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            size_cfg_ff <= size_cfg_in;
         end
         if (accept) begin
            fill_ff         <= fill_in;
            start_ff        <= start_in;
            len_ff          <= len_in;
            pos_ff          <= pos_in;
            active_ff       <= active_in;
            blocks_ff       <= blocks_in;
            crc_a_ff        <= crc_a_in;
            crc_b_ff        <= crc_b_in;
            frag_open_ff    <= frag_open_in;
            payload_open_ff <= payload_open_in;
            is_first_ff     <= is_first_in;
            flushed_ff      <= flushed_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_fill_in_block: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= active_ff)
      else $error("fill offset beyond block size");
   a_open_pos: assert property (@(posedge clock) disable iff (reset)
      frag_open_ff |-> (pos_ff < active_ff))
      else $error("open fragment has no room left");
   a_open_payload: assert property (@(posedge clock) disable iff (reset)
      frag_open_ff |-> payload_open_ff)
      else $error("fragment open outside a payload");
`endif

endmodule

// ===== rtl/lrf_queue.sv =====
`timescale 1ns / 1ps
module lrf_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrf_pkg::cmd_type  push_data,
   output logic              in_ready,
   output logic              out_valid,
   output lrf_pkg::cmd_type  out_data,
   input  logic              pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   lrf_pkg::cmd_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/lrf_back.sv =====
`timescale 1ns / 1ps
module lrf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lrf_pkg::cmd_type  cmd,
   output logic              pop,
   lrf_rsp_if.source         rsp_ch
);

   localparam logic [3:0] STEP_DONE   = 4'd0;
   localparam logic [3:0] STEP_DATA   = 4'd1;
   localparam logic [3:0] STEP_TYPE   = 4'd2;
   localparam logic [3:0] STEP_LEN_LO = 4'd3;
   localparam logic [3:0] STEP_LEN_HI = 4'd4;
   localparam logic [3:0] STEP_CRC_0  = 4'd5;
   localparam logic [3:0] STEP_CRC_1  = 4'd6;
   localparam logic [3:0] STEP_CRC_2  = 4'd7;
   localparam logic [3:0] STEP_CRC_3  = 4'd8;

   logic [3:0]                    step_ff, step_in;
   logic                          valid_ff;
   lrf_pkg::kind_type             kind_ff, kind_in;
   logic [lrf_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [lrf_pkg::COUNT_W-1:0]   count_ff;
   logic                          flushed_ff;
   logic                          run_end_ff;

   logic [8:0]  present, rem;
   logic [3:0]  eff;
   logic        last;
   logic        load;
   logic [31:0] masked;

   assign present = {{7{cmd.hdr_valid}}, cmd.data_valid, cmd.done_valid};
   assign rem     = present & ~((9'd1 << step_ff) - 9'd1);
   assign last    = ((rem & ~(9'd1 << eff)) == 9'd0);
   assign load    = cmd_valid && (!valid_ff || rsp_ch.ready);
   assign pop     = load && last;
   assign masked  = lrf_pkg::crc_mask(cmd.hdr_crc);
   assign step_in = last ? STEP_DONE : eff + 4'd1;

   always_comb begin
      eff = STEP_DONE;
      for (int i = 8; i >= 0; i--) begin
         if (rem[i]) begin
            eff = 4'(i);
         end
      end
   end

   always_comb begin
      kind_in   = lrf_pkg::KIND_HEADER;
      offset_in = cmd.hdr_start + lrf_pkg::OFFSET_W'(eff - STEP_TYPE);
      byte_in   = 8'h00;
      case (eff)
         STEP_DONE: begin
            kind_in   = lrf_pkg::KIND_DONE;
            offset_in = cmd.done_offset;
         end
         STEP_DATA: begin
            kind_in   = lrf_pkg::KIND_DATA;
            offset_in = cmd.data_offset;
            byte_in   = cmd.data_byte;
         end
         STEP_TYPE:   byte_in = 8'(cmd.hdr_kind);
         STEP_LEN_LO: byte_in = cmd.hdr_length[7:0];
         STEP_LEN_HI: byte_in = cmd.hdr_length[15:8];
         STEP_CRC_0:  byte_in = masked[7:0];
         STEP_CRC_1:  byte_in = masked[15:8];
         STEP_CRC_2:  byte_in = masked[23:16];
         STEP_CRC_3:  byte_in = masked[31:24];
         default: begin
            kind_in   = lrf_pkg::KIND_DATA;
            offset_in = cmd.data_offset;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= STEP_DONE;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            step_ff  <= step_in;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         offset_ff  <= offset_in;
         byte_ff    <= byte_in;
         count_ff   <= cmd.count;
         flushed_ff <= cmd.flushed;
         run_end_ff <= last;
      end
   end

   assign rsp_ch.valid                  = valid_ff;
   assign rsp_ch.kind                   = kind_ff;
   assign rsp_ch.offset                 = offset_ff;
   assign rsp_ch.out_byte               = byte_ff;
   assign rsp_ch.block_count            = count_ff;
   assign rsp_ch.flushed_during_payload = flushed_ff;
   assign rsp_ch.run_end                = run_end_ff;

`ifndef SYNTHESIS
   a_step_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == STEP_DONE))
      else $error("step not rewound after command retired");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_BLOCK   = 32768;
   localparam int IDLE_PCT    = 27;
   localparam int DRAIN_WAIT  = 24;
   localparam int CYCLE_LIMIT = 20000;

   typedef struct packed {
      lrf_pkg::opcode_type opcode;
      logic [7:0]          data_byte;
      logic                last;
   } req_item_type;

   typedef struct packed {
      lrf_pkg::kind_type            kind;
      logic [lrf_pkg::OFFSET_W-1:0] offset;
      logic [7:0]                   out_byte;
      logic [lrf_pkg::COUNT_W-1:0]  block_count;
      logic                         flushed;
      logic                         run_end;
   } block_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrf_req_if req_if ();
   lrf_rsp_if rsp_if ();
   lrf_csr_if csr_if ();

   log_record_fragmenter_crc32c_top #(.MAX_BLOCK_BYTES(MAX_BLOCK)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .csr_ch (csr_if),
      .rsp_ch (rsp_if)
   );

   logic                      req_valid  = 1'b0;
   logic                      req_opcode = 1'b0;
   logic [7:0]                req_byte   = 8'h00;
   logic                      req_last   = 1'b0;
   logic                      rsp_ready  = 1'b0;
   logic                      csr_valid  = 1'b0;
   logic [lrf_pkg::CSR_W-1:0] csr_data   = '0;

   assign req_if.valid        = req_valid;
   assign req_if.opcode       = req_opcode;
   assign req_if.data_byte    = req_byte;
   assign req_if.payload_last = req_last;
   assign rsp_if.ready        = rsp_ready;
   assign csr_if.valid        = csr_valid;
   assign csr_if.data         = csr_data;

   always #6 clock = ~clock;

   // fragmenter state as seen from the block buffer
   logic [15:0] size_reg;
   logic [15:0] size_active;
   logic [15:0] fill_pos;
   logic [15:0] frag_start;
   logic [15:0] frag_len;
   logic [31:0] blocks_closed;
   logic [31:0] crc_end;
   logic [31:0] crc_cont;
   logic        frag_open;
   logic        payload_open;
   logic        frag_first;
   logic        flushed_flag;

   req_item_type    byte_requests[$];
   block_write_type step_writes[$];
   block_write_type expected_writes[$];

   logic        req_fire = 1'b0;
   logic        csr_fire = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned req_count = 0;
   int unsigned result_count = 0;
   int unsigned csr_writes = 0;

   function automatic logic [15:0] clamp_size(logic [15:0] s);
      if (s < 16'(lrf_pkg::MIN_BLOCK_BYTES)) return 16'(lrf_pkg::MIN_BLOCK_BYTES);
      if (32'(s) > MAX_BLOCK) return 16'(MAX_BLOCK);
      return s;
   endfunction

   function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] r;
      r = crc ^ 32'hFFFF_FFFF;
      r[7:0] = r[7:0] ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ lrf_pkg::CRC_POLY) : (r >> 1);
      end
      return r ^ 32'hFFFF_FFFF;
   endfunction

   function automatic void model_reset();
      size_reg      = 16'(lrf_pkg::BLOCK_SIZE_RESET);
      size_active   = clamp_size(size_reg);
      fill_pos      = '0;
      frag_start    = '0;
      frag_len      = '0;
      blocks_closed = '0;
      crc_end       = '0;
      crc_cont      = '0;
      frag_open     = 1'b0;
      payload_open  = 1'b0;
      frag_first    = 1'b1;
      flushed_flag  = 1'b0;
   endfunction

   function automatic void add_write(lrf_pkg::kind_type k, int unsigned off, logic [7:0] b);
      block_write_type w;
      w.kind        = k;
      w.offset      = off[lrf_pkg::OFFSET_W-1:0];
      w.out_byte    = b;
      w.block_count = blocks_closed;
      w.flushed     = flushed_flag;
      w.run_end     = 1'b0;
      step_writes.push_back(w);
   endfunction

   function automatic void close_block();
      blocks_closed = blocks_closed + 32'd1;
      add_write(lrf_pkg::KIND_DONE, 32'(fill_pos), 8'h00);
      fill_pos = '0;
   endfunction

   function automatic void close_fragment(lrf_pkg::frag_kind_type t, logic [31:0] crc);
      logic [31:0] m;
      int unsigned s;
      m = {crc[14:0], crc[31:15]} + lrf_pkg::MASK_DELTA;
      s = 32'(frag_start);
      add_write(lrf_pkg::KIND_HEADER, s, 8'(t));
      add_write(lrf_pkg::KIND_HEADER, s + 1, frag_len[7:0]);
      add_write(lrf_pkg::KIND_HEADER, s + 2, frag_len[15:8]);
      for (int k = 0; k < 4; k++) begin
         add_write(lrf_pkg::KIND_HEADER, s + 3 + k, m[8*k +: 8]);
      end
      fill_pos  = 16'(s + lrf_pkg::HEADER_BYTES + 32'(frag_len));
      frag_open = 1'b0;
   endfunction

   function automatic void fragment_predict(req_item_type r);
      block_write_type w;
      step_writes.delete();
      if (r.opcode == lrf_pkg::OP_FLUSH) begin
         if (!payload_open && fill_pos != 0) close_block();
      end else begin
         if (!frag_open) begin
            if (!payload_open) begin
               payload_open = 1'b1;
               flushed_flag = 1'b0;
            end
            if (32'(fill_pos) + lrf_pkg::HEADER_BYTES >= 32'(size_active)) begin
               flushed_flag = 1'b1;
               close_block();
            end
            if (fill_pos == 0) size_active = clamp_size(size_reg);
            frag_start = fill_pos;
            frag_len   = '0;
            frag_open  = 1'b1;
            crc_end  = crc_step(32'h0, frag_first ? 8'(lrf_pkg::FRAG_FULL)
                                                  : 8'(lrf_pkg::FRAG_LAST));
            crc_cont = crc_step(32'h0, frag_first ? 8'(lrf_pkg::FRAG_FIRST)
                                                  : 8'(lrf_pkg::FRAG_MIDDLE));
         end
         add_write(lrf_pkg::KIND_DATA,
                   32'(frag_start) + lrf_pkg::HEADER_BYTES + 32'(frag_len), r.data_byte);
         crc_end  = crc_step(crc_end, r.data_byte);
         crc_cont = crc_step(crc_cont, r.data_byte);
         frag_len = frag_len + 16'd1;
         if (r.last) begin
            close_fragment(frag_first ? lrf_pkg::FRAG_FULL : lrf_pkg::FRAG_LAST, crc_end);
            frag_first   = 1'b1;
            payload_open = 1'b0;
         end else if (32'(frag_start) + lrf_pkg::HEADER_BYTES + 32'(frag_len)
                      >= 32'(size_active)) begin
            close_fragment(frag_first ? lrf_pkg::FRAG_FIRST : lrf_pkg::FRAG_MIDDLE,
                           crc_cont);
            frag_first = 1'b0;
         end
      end
      foreach (step_writes[i]) begin
         w = step_writes[i];
         w.run_end = (i == step_writes.size() - 1);
         expected_writes.push_back(w);
      end
   endfunction

   function automatic void report_mismatch(string what, block_write_type want,
                                           block_write_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected kind %0d off %0d byte %02h count %0d flushed %0b end %0b",
                  what, want.kind, want.offset, want.out_byte, want.block_count,
                  want.flushed, want.run_end);
         $display("   got kind %0d off %0d byte %02h count %0d flushed %0b end %0b",
                  got.kind, got.offset, got.out_byte, got.block_count, got.flushed,
                  got.run_end);
      end
   endfunction

   function automatic bit take_idle();
      if (cycle_count % 5000 >= 3800) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
                  expected_writes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_item_type    cur;
      block_write_type got;
      block_write_type want;
      req_fire = 1'b0;
      csr_fire = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_if.ready) begin
            size_reg = csr_data;
            csr_fire = 1'b1;
         end
         if (req_valid && req_if.ready) begin
            req_fire      = 1'b1;
            cur.opcode    = lrf_pkg::opcode_type'(req_opcode);
            cur.data_byte = req_byte;
            cur.last      = req_last;
            req_count++;
            fragment_predict(cur);
         end
         if (rsp_ready && rsp_if.valid) begin
            got.kind        = lrf_pkg::kind_type'(rsp_if.kind);
            got.offset      = rsp_if.offset;
            got.out_byte    = rsp_if.out_byte;
            got.block_count = rsp_if.block_count;
            got.flushed     = rsp_if.flushed_during_payload;
            got.run_end     = rsp_if.run_end;
            result_count++;
            if (expected_writes.size() == 0) begin
               report_mismatch("unexpected write", '0, got);
            end else begin
               want = expected_writes.pop_front();
               if (want !== got) report_mismatch("write mismatch", want, got);
            end
         end
      end
   end

   always @(negedge clock) begin
      req_item_type nxt;
      if (!reset && (!req_valid || req_fire)) begin
         if (byte_requests.size() > 0 && !take_idle()) begin
            nxt = byte_requests.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= nxt.opcode;
            req_byte   <= nxt.data_byte;
            req_last   <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && !take_idle();
   end

   function automatic void push_req(lrf_pkg::opcode_type op, logic [7:0] b, logic last);
      req_item_type it;
      it.opcode    = op;
      it.data_byte = b;
      it.last      = last;
      byte_requests.push_back(it);
   endfunction

   task automatic set_block_size(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic drain();
      while (byte_requests.size() != 0 || req_valid || expected_writes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic random_phase(int n_items, logic [15:0] bs);
      int made;
      int len;
      int cap;
      set_block_size(bs);
      cap = (32'(clamp_size(bs)) * 3 > 40) ? 40 : 32'(clamp_size(bs)) * 3;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(99) < 12) begin
            push_req(lrf_pkg::OP_FLUSH, 8'($urandom), 1'($urandom));
            made++;
         end else begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, cap) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               // drop a flush into the open payload now and then
               if (i == len / 2 && $urandom_range(9) == 0) begin
                  push_req(lrf_pkg::OP_FLUSH, 8'($urandom), 1'($urandom));
               end
               push_req(lrf_pkg::OP_BYTE, 8'($urandom), i == len - 1);
            end
            made += len;
         end
      end
      drain();
   endtask

   initial begin
      model_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_block_size(16'h0000);
      push_req(lrf_pkg::OP_FLUSH, 8'hFF, 1'b1);
      push_req(lrf_pkg::OP_BYTE, 8'h00, 1'b1);
      push_req(lrf_pkg::OP_BYTE, 8'hFF, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h5A, 1'b0);
      push_req(lrf_pkg::OP_FLUSH, 8'h00, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'hA5, 1'b1);
      push_req(lrf_pkg::OP_FLUSH, 8'h00, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h12, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h34, 1'b1);
      push_req(lrf_pkg::OP_FLUSH, 8'h00, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h01, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h02, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h03, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h04, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'h80, 1'b1);
      push_req(lrf_pkg::OP_BYTE, 8'h7F, 1'b0);
      push_req(lrf_pkg::OP_BYTE, 8'hC3, 1'b1);
      push_req(lrf_pkg::OP_FLUSH, 8'h00, 1'b0);
      drain();

      random_phase(10, 16'd9);
      random_phase(10, 16'd8);
      random_phase(10, 16'($urandom_range(10, 40)));
      random_phase(10, 16'hFFFF);
      random_phase(10, 16'($urandom_range(9, 24)));
      random_phase(10, 16'd13);

      $display("ran %0d requests into %0d block writes, %0d blocks closed",
               req_count, result_count, blocks_closed);
      $display("block size written %0d times, from below the minimum to above the maximum",
               csr_writes);
      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lrf_pkg.sv
rtl/lrf_req_if.sv
rtl/lrf_rsp_if.sv
rtl/lrf_csr_if.sv
rtl/lrf_front.sv
rtl/lrf_queue.sv
rtl/lrf_back.sv
rtl/log_record_fragmenter_crc32c_top.sv
dv/tb_top.sv
